>>> hdl/ggvc_pkg.sv
// Shared types, constants and CORDIC angle table for the go-to-goal controller.
`timescale 1ns / 1ps
`default_nettype none
package ggvc_pkg;

   localparam int CORDIC_STEPS = 16;   // 8 .. 24
   localparam int NSTG         = 2 * CORDIC_STEPS + 4;
   localparam int VEC0         = 2;
   localparam int WRAP         = 2 + CORDIC_STEPS;
   localparam int FOLD         = 3 + CORDIC_STEPS;
   localparam int ROT0         = 4 + CORDIC_STEPS;

   localparam int XW = 32;   // CORDIC x/y
   localparam int ZW = 26;   // angle, radians * 2^20
   localparam int HW = 23;   // heading * 128
   localparam int PW = 48;   // gain products

   localparam logic signed [ZW-1:0] ANG_PI      = ZW'(3294199);
   localparam logic signed [ZW-1:0] ANG_HALF_PI = ZW'(1647099);
   localparam logic signed [ZW-1:0] ANG_TWO_PI  = ZW'(6588398);
   localparam logic signed [XW-1:0] INV_GAIN    = XW'(652032875);

   localparam logic [14:0] LIN_GAIN_RST = 15'd9830;
   localparam logic [14:0] ANG_GAIN_RST = 15'd9830;
   localparam logic [14:0] STOP_RST     = 15'd614;

   typedef enum logic [2:0] {
      CSR_GOAL_X       = 3'd0,
      CSR_GOAL_Y       = 3'd1,
      CSR_LINEAR_GAIN  = 3'd2,
      CSR_ANGULAR_GAIN = 3'd3,
      CSR_STOP_DIST    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic signed [HW-1:0] hd;
      logic                 arr;
      logic                 neg;
   } pipe_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic                 arr;
      logic                 neg;
   } scale_type;

   function automatic logic signed [ZW-1:0] atan_q20(input int i);
      logic [20:0] v;
      case (i)
         0:  v = 21'd823550;
         1:  v = 21'd486170;
         2:  v = 21'd256879;
         3:  v = 21'd130396;
         4:  v = 21'd65451;
         5:  v = 21'd32757;
         6:  v = 21'd16383;
         7:  v = 21'd8192;
         8:  v = 21'd4096;
         9:  v = 21'd2048;
         10: v = 21'd1024;
         11: v = 21'd512;
         12: v = 21'd256;
         13: v = 21'd128;
         14: v = 21'd64;
         15: v = 21'd32;
         16: v = 21'd16;
         17: v = 21'd8;
         18: v = 21'd4;
         19: v = 21'd2;
         20: v = 21'd1;
         default: v = 21'd0;
      endcase
      return ZW'(signed'({1'b0, v}));
   endfunction

endpackage
`default_nettype wire

>>> hdl/ggvc_scale.sv
// Gain multiply, rounding, saturation and output register with skid stage.
`timescale 1ns / 1ps
`default_nettype none
module ggvc_scale (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire ggvc_pkg::scale_type in_data,
   output logic                     in_ready,
   input  wire logic [14:0]         linear_gain,
   input  wire logic [14:0]         angular_gain,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [15:0]       rsp_linear_velocity,
   output logic signed [15:0]       rsp_angular_velocity,
   output logic                     rsp_arrived
);
   import ggvc_pkg::*;

   typedef struct packed {
      logic signed [15:0] lin;
      logic signed [15:0] ang;
      logic               arr;
   } res_type;

   logic                 a_vld_ff, b_vld_ff, o_vld_ff, s_vld_ff;
   logic signed [PW-1:0] a_px_ff, a_py_ff;
   logic                 a_arr_ff, a_neg_ff;
   res_type              b_ff, b_in, o_ff, s_ff;
   logic                 en;

   assign en       = !s_vld_ff;
   assign in_ready = en;

   function automatic logic signed [15:0] round_sat(input logic signed [PW-1:0] p,
                                                    input logic neg);
      logic signed [PW-1:0] q;
      logic signed [PW-1:0] r;
      q = neg ? -p : p;
      r = (q + PW'(64'sd1 <<< 29)) >>> 30;
      if (r > PW'(32767))       return 16'sh7fff;
      else if (r < -PW'(32768)) return 16'sh8000;
      else                      return r[15:0];
   endfunction

   always_comb begin
      b_in.arr = a_arr_ff;
      if (a_arr_ff) begin
         b_in.lin = '0;
         b_in.ang = '0;
      end else begin
         b_in.lin = round_sat(a_px_ff, a_neg_ff);
         b_in.ang = round_sat(a_py_ff, a_neg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
      end else begin
         if (en) begin
            a_vld_ff <= in_valid;
            b_vld_ff <= a_vld_ff;
         end
         if (!o_vld_ff || !rsp_stall) begin
            o_vld_ff <= s_vld_ff || b_vld_ff;
            s_vld_ff <= 1'b0;
         end else if (b_vld_ff && en) begin
            s_vld_ff <= 1'b1;
         end
      end
      if (en) begin
         a_px_ff  <= signed'({1'b0, linear_gain}) * in_data.x;
         a_py_ff  <= signed'({1'b0, angular_gain}) * in_data.y;
         a_arr_ff <= in_data.arr;
         a_neg_ff <= in_data.neg;
         b_ff     <= b_in;
      end
      if (!o_vld_ff || !rsp_stall) begin
         o_ff <= s_vld_ff ? s_ff : b_ff;
      end else if (b_vld_ff && en) begin
         s_ff <= b_ff;
      end
   end

   assign rsp_valid            = o_vld_ff;
   assign rsp_linear_velocity  = o_ff.lin;
   assign rsp_angular_velocity = o_ff.ang;
   assign rsp_arrived          = o_ff.arr;

endmodule
`default_nettype wire

>>> hdl/go_to_goal_velocity_controller_top.sv
// Top level: configuration, distance test, CORDIC pipeline, output scaling.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   pos_x, pos_y, heading
//  rsp      out        rsp_valid/rsp_stall   linear_velocity, angular_velocity, arrived
//  csr      in         csr_we                csr_index, csr_wdata
//
// One item per cycle while not stalled. Stages: capture, distance test, one
// stage per CORDIC iteration in each of the two CORDICs, angle wrap, fold,
// two scaling stages and the output register.
// A skid stage behind the output register keeps input open for one more item
// while a result is stalled. Synchronous reset clears all valid bits.
`timescale 1ns / 1ps
`default_nettype none
module go_to_goal_velocity_controller_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic signed [15:0] req_heading,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_linear_velocity,
   output logic signed [15:0]      rsp_angular_velocity,
   output logic                    rsp_arrived,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);
   import ggvc_pkg::*;

   logic signed [15:0] goal_x_ff, goal_y_ff;
   logic [14:0]        lin_gain_ff, ang_gain_ff, stop_ff;
   logic [29:0]        stop_sq_ff;

   pipe_type           pipe_ff [NSTG];
   pipe_type           pipe_in [NSTG];
   logic [NSTG-1:0]    vld_ff;
   logic               en;
   scale_type          sc_in;

   logic signed [16:0] dxn, dyn;
   logic signed [33:0] sqx, sqy;
   logic [34:0]        dist_sq;
   logic signed [ZW-1:0] rel;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff   <= '0;
         goal_y_ff   <= '0;
         lin_gain_ff <= LIN_GAIN_RST;
         ang_gain_ff <= ANG_GAIN_RST;
         stop_ff     <= STOP_RST;
         stop_sq_ff  <= 30'(STOP_RST * STOP_RST);
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GOAL_X:       goal_x_ff   <= csr_wdata;
               CSR_GOAL_Y:       goal_y_ff   <= csr_wdata;
               CSR_LINEAR_GAIN:  lin_gain_ff <= csr_wdata[14:0];
               CSR_ANGULAR_GAIN: ang_gain_ff <= csr_wdata[14:0];
               CSR_STOP_DIST:    stop_ff     <= csr_wdata[14:0];
               default: ;
            endcase
         end
         stop_sq_ff <= stop_ff * stop_ff;
      end
   end

   always_comb begin
      dxn = pipe_ff[0].x[16:0];
      dyn = pipe_ff[0].y[16:0];
      sqx = dxn * dxn;
      sqy = dyn * dyn;
      dist_sq = {1'b0, sqx[33:0]} + {1'b0, sqy[33:0]};
      rel = '0;

      // capture
      pipe_in[0].x   = XW'(17'(goal_x_ff) - 17'(req_pos_x));
      pipe_in[0].y   = XW'(17'(goal_y_ff) - 17'(req_pos_y));
      pipe_in[0].z   = '0;
      pipe_in[0].hd  = HW'(req_heading) <<< 7;
      pipe_in[0].arr = 1'b0;
      pipe_in[0].neg = 1'b0;

      // distance test and vectoring start (left half plane rotated by pi)
      pipe_in[1]     = pipe_ff[0];
      pipe_in[1].arr = dist_sq <= {5'b0, stop_sq_ff};
      if (dxn < 0) begin
         pipe_in[1].x = -(XW'(dxn) <<< 12);
         pipe_in[1].y = -(XW'(dyn) <<< 12);
         pipe_in[1].z = ANG_PI;
      end else begin
         pipe_in[1].x = XW'(dxn) <<< 12;
         pipe_in[1].y = XW'(dyn) <<< 12;
         pipe_in[1].z = '0;
      end

      for (int i = 0; i < CORDIC_STEPS; i++) begin
         pipe_in[VEC0+i] = pipe_ff[VEC0+i-1];
         if (pipe_ff[VEC0+i-1].y >= 0) begin
            pipe_in[VEC0+i].x = pipe_ff[VEC0+i-1].x + (pipe_ff[VEC0+i-1].y >>> i);
            pipe_in[VEC0+i].y = pipe_ff[VEC0+i-1].y - (pipe_ff[VEC0+i-1].x >>> i);
            pipe_in[VEC0+i].z = pipe_ff[VEC0+i-1].z + atan_q20(i);
         end else begin
            pipe_in[VEC0+i].x = pipe_ff[VEC0+i-1].x - (pipe_ff[VEC0+i-1].y >>> i);
            pipe_in[VEC0+i].y = pipe_ff[VEC0+i-1].y + (pipe_ff[VEC0+i-1].x >>> i);
            pipe_in[VEC0+i].z = pipe_ff[VEC0+i-1].z - atan_q20(i);
         end
      end

      // relative angle into (-pi, pi]; one correction covers the whole range
      pipe_in[WRAP] = pipe_ff[WRAP-1];
      rel = pipe_ff[WRAP-1].z - ZW'(pipe_ff[WRAP-1].hd);
      if (rel > ANG_PI)        pipe_in[WRAP].z = rel - ANG_TWO_PI;
      else if (rel <= -ANG_PI) pipe_in[WRAP].z = rel + ANG_TWO_PI;
      else                     pipe_in[WRAP].z = rel;

      // fold into +-pi/2, results negated later
      pipe_in[FOLD]     = pipe_ff[FOLD-1];
      pipe_in[FOLD].x   = INV_GAIN;
      pipe_in[FOLD].y   = '0;
      pipe_in[FOLD].neg = 1'b0;
      if (pipe_ff[FOLD-1].z > ANG_HALF_PI) begin
         pipe_in[FOLD].z   = pipe_ff[FOLD-1].z - ANG_PI;
         pipe_in[FOLD].neg = 1'b1;
      end else if (pipe_ff[FOLD-1].z < -ANG_HALF_PI) begin
         pipe_in[FOLD].z   = pipe_ff[FOLD-1].z + ANG_PI;
         pipe_in[FOLD].neg = 1'b1;
      end

      for (int i = 0; i < CORDIC_STEPS; i++) begin
         pipe_in[ROT0+i] = pipe_ff[ROT0+i-1];
         if (pipe_ff[ROT0+i-1].z >= 0) begin
            pipe_in[ROT0+i].x = pipe_ff[ROT0+i-1].x - (pipe_ff[ROT0+i-1].y >>> i);
            pipe_in[ROT0+i].y = pipe_ff[ROT0+i-1].y + (pipe_ff[ROT0+i-1].x >>> i);
            pipe_in[ROT0+i].z = pipe_ff[ROT0+i-1].z - atan_q20(i);
         end else begin
            pipe_in[ROT0+i].x = pipe_ff[ROT0+i-1].x + (pipe_ff[ROT0+i-1].y >>> i);
            pipe_in[ROT0+i].y = pipe_ff[ROT0+i-1].y - (pipe_ff[ROT0+i-1].x >>> i);
            pipe_in[ROT0+i].z = pipe_ff[ROT0+i-1].z + atan_q20(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_valid};
      end
      if (en) begin
         for (int k = 0; k < NSTG; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign req_stall = !en;

   assign sc_in.x   = pipe_ff[NSTG-1].x;
   assign sc_in.y   = pipe_ff[NSTG-1].y;
   assign sc_in.arr = pipe_ff[NSTG-1].arr;
   assign sc_in.neg = pipe_ff[NSTG-1].neg;

   ggvc_scale u_scale (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (vld_ff[NSTG-1]),
      .in_data              (sc_in),
      .in_ready             (en),
      .linear_gain          (lin_gain_ff),
      .angular_gain         (ang_gain_ff),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_linear_velocity  (rsp_linear_velocity),
      .rsp_angular_velocity (rsp_angular_velocity),
      .rsp_arrived          (rsp_arrived)
   );

   a_arrived_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_arrived |-> rsp_linear_velocity == 16'sd0 &&
                                   rsp_angular_velocity == 16'sd0)
      else $error("arrived item with nonzero velocity");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("accepted item lost at capture stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
`default_nettype wire
